@@ rtl/core/wbc_pkg.sv @@
// Shared types and constants of the word memory bytecode processor.
package wbc_pkg;

	// Item kinds carried in the low bits of the input transfer.
	localparam logic [1:0] ITEM_WRITE  = 2'd0;
	localparam logic [1:0] ITEM_EXEC   = 2'd1;
	localparam logic [1:0] ITEM_READ   = 2'd2;
	localparam logic [1:0] ITEM_UNUSED = 2'd3;

	// Instruction opcodes.
	localparam logic [15:0] OPC_NOP   = 16'h0000;
	localparam logic [15:0] OPC_SET   = 16'h0020;
	localparam logic [15:0] OPC_OUT   = 16'h0022;
	localparam logic [15:0] OPC_ADD   = 16'h0024;
	localparam logic [15:0] OPC_COPY  = 16'h0025;
	localparam logic [15:0] OPC_SUB   = 16'h0026;
	localparam logic [15:0] OPC_JMP   = 16'h0027;
	localparam logic [15:0] OPC_CMPJ  = 16'h0028;
	localparam logic [15:0] OPC_JFWD  = 16'h0029;
	localparam logic [15:0] OPC_JBACK = 16'h0030;
	localparam logic [15:0] OPC_BNE   = 16'h0031;
	localparam logic [15:0] OPC_MUL   = 16'h0032;
	localparam logic [15:0] OPC_DIV   = 16'h0033;
	localparam logic [15:0] OPC_BGT   = 16'h0034;
	localparam logic [15:0] OPC_BLT   = 16'h0035;
	localparam logic [15:0] OPC_BLE   = 16'h0036;
	localparam logic [15:0] OPC_BGE   = 16'h0037;
	localparam logic [15:0] OPC_HALT  = 16'h0038;

	// Fixed result addresses.
	localparam logic [15:0] ADR_SUM    = 16'hFFF1;
	localparam logic [15:0] ADR_DIFF   = 16'hFFF3;
	localparam logic [15:0] ADR_BORROW = 16'hFFF5;
	localparam logic [15:0] ADR_PROD   = 16'hFFF7;
	localparam logic [15:0] ADR_QUOT   = 16'hFFF9;
	localparam logic [15:0] ADR_REM    = 16'hFFFB;

	// One write request to the word store.
	typedef struct packed {
		logic        en;
		logic [15:0] addr;
		logic [15:0] data;
	} wr_req_t;

endpackage

@@ rtl/core/wbc_store.sv @@
// Word store: one write port, one registered read port, clearing pass after reset.
module wbc_store #(
	parameter int ADDR_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wbc_pkg::wr_req_t   wr,
	input  logic [15:0]        rd_addr,
	output logic [15:0]        rd_data,
	output logic               clr_busy
);

	localparam int Depth = 1 << ADDR_BITS;

	logic [15:0]          mem [Depth];
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {ADDR_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr[ADDR_BITS-1:0]] <= wr.data;
		end
		rd_data <= mem[rd_addr[ADDR_BITS-1:0]];
	end

	assign clr_busy = clr_busy_q;

endmodule

@@ rtl/core/wbc_div.sv @@
// Restoring 16-bit divider, one quotient bit per cycle.
module wbc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [15:0] quot,
	output logic [15:0] rem
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] dsr_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[15]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'hF) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

@@ rtl/core/word_memory_bytecode_cpu.sv @@
// Top level: item sequencer, instruction fetch and execute around the word store.
//
//  Channel | Direction | Payload (lowest bit first)
//  s_*     | in        | op[1:0], mem_addr[17:2], mem_data[33:18], zero pad to 40
//  m_*     | out       | out_value[15:0], read_data[31:16], prog_counter[47:32],
//          |           | halted[48], zero pad to 56
//
// Items are handled one at a time. A write, an op code 3 or an execute after halt
// goes from accept straight to the result register; a read first passes the read-data
// state. An instruction passes the accept, the seven dependent reads through the single
// store read port, then execute, two write-back slots and the result register; a
// divide also waits for the bit-serial divider. After reset the store is cleared one
// word per cycle while s_tready stays low. A finished result waits in the output
// register; the sequencer stalls on the next result only while that register is
// still full.
module word_memory_bytecode_cpu #(
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // op, mem_addr, mem_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // out_value, read_data, prog_counter, halted
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RDATA = 8'b0000_0010,
		ST_FETCH = 8'b0000_0100,
		ST_EXEC  = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_WR1   = 8'b0010_0000,
		ST_WR2   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [2:0]           step_q;
	logic [15:0]          words_q [7];   // opcode, a, b, c, d, M[a], M[b]
	logic [ADDR_BITS-1:0] pc_q;
	logic [15:0]          out_q;
	logic                 halt_q;
	logic [15:0]          rdata_q;
	wbc_pkg::wr_req_t     wr1_q;
	wbc_pkg::wr_req_t     wr2_q;
	logic                 m_tvalid_q;
	logic [55:0]          m_tdata_q;

	wbc_pkg::wr_req_t     wr_req;
	logic [15:0]          rd_addr;
	logic [15:0]          rd_data;
	logic                 clr_busy;
	logic                 accept;
	logic [1:0]           in_op;
	logic [15:0]          in_addr;
	logic [15:0]          in_data;

	// Execute-stage decode results.
	logic [ADDR_BITS-1:0] ex_npc;
	logic [15:0]          ex_out;
	logic                 ex_halt;
	logic                 ex_div;
	wbc_pkg::wr_req_t     ex_wr1;
	wbc_pkg::wr_req_t     ex_wr2;

	logic                 div_start;
	logic                 div_busy;
	logic                 div_done;
	logic [15:0]          div_quot;
	logic [15:0]          div_rem;

	assign in_op    = s_tdata[1:0];
	assign in_addr  = s_tdata[17:2];
	assign in_data  = s_tdata[33:18];
	assign s_tready = (state_q == ST_IDLE) && !clr_busy;
	assign accept   = s_tvalid && s_tready;

	wbc_store #(.ADDR_BITS(ADDR_BITS)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr_req),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clr_busy (clr_busy)
	);

	assign div_start = (state_q == ST_EXEC) && ex_div;

	wbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (words_q[5]),
		.divisor  (words_q[6]),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Read address: the item address on accept, else the fetch sequence.
	always_comb begin
		logic [ADDR_BITS-1:0] seq;
		seq = pc_q;
		case (step_q)
			3'd0: seq = pc_q;
			3'd1: seq = pc_q + ADDR_BITS'(1);
			3'd2: seq = pc_q + ADDR_BITS'(2);
			3'd3: seq = pc_q + ADDR_BITS'(3);
			3'd4: seq = pc_q + ADDR_BITS'(4);
			3'd5: seq = words_q[1][ADDR_BITS-1:0];
			3'd6: seq = words_q[2][ADDR_BITS-1:0];
			default: seq = pc_q;
		endcase
		if (state_q == ST_FETCH) begin
			rd_addr = 16'(seq);
		end else begin
			rd_addr = in_addr;
		end
	end

	// Store write port.
	always_comb begin
		wr_req = '0;
		if (accept && in_op == wbc_pkg::ITEM_WRITE) begin
			wr_req.en   = 1'b1;
			wr_req.addr = in_addr;
			wr_req.data = in_data;
		end else if (state_q == ST_WR1) begin
			wr_req = wr1_q;
		end else if (state_q == ST_WR2) begin
			wr_req = wr2_q;
		end
	end

	// Instruction decode and execute on the fetched words.
	always_comb begin
		logic [15:0]          opc, a, b, c, d, x, y;
		logic [ADDR_BITS-1:0] br_taken;
		logic                 taken;
		logic [31:0]          prod;
		opc = words_q[0];
		a   = words_q[1];
		b   = words_q[2];
		c   = words_q[3];
		d   = words_q[4];
		x   = words_q[5];
		y   = words_q[6];
		prod     = x * y;
		br_taken = pc_q + ADDR_BITS'(3) + ADDR_BITS'({1'b0, c[15:1]});
		taken    = 1'b0;
		ex_npc   = pc_q + ADDR_BITS'(1);
		ex_out   = '0;
		ex_halt  = halt_q;
		ex_div   = 1'b0;
		ex_wr1   = '0;
		ex_wr2   = '0;
		case (opc)
			wbc_pkg::OPC_SET: begin
				ex_wr1 = '{en: 1'b1, addr: a, data: b};
				ex_npc = pc_q + ADDR_BITS'(3);
			end
			wbc_pkg::OPC_OUT: begin
				ex_out = x;
				ex_npc = pc_q + ADDR_BITS'(2);
			end
			wbc_pkg::OPC_ADD: begin
				ex_wr1 = '{en: 1'b1, addr: wbc_pkg::ADR_SUM, data: 16'(x + y)};
				ex_npc = pc_q + ADDR_BITS'(3);
			end
			wbc_pkg::OPC_COPY: begin
				ex_wr1 = '{en: 1'b1, addr: b, data: x};
				ex_npc = pc_q + ADDR_BITS'(3);
			end
			wbc_pkg::OPC_SUB: begin
				// A subtract only ever writes one to the borrow flag, and only on a borrow; it never clears it.
				ex_wr1 = '{en: (x < y), addr: wbc_pkg::ADR_BORROW, data: 16'd1};
				ex_wr2 = '{en: 1'b1, addr: wbc_pkg::ADR_DIFF, data: 16'(x - y)};
				ex_npc = pc_q + ADDR_BITS'(3);
			end
			wbc_pkg::OPC_JMP: begin
				ex_npc = ADDR_BITS'({1'b0, a[15:1]});
			end
			wbc_pkg::OPC_CMPJ: begin
				ex_out = out_q;
				ex_npc = (x == y) ? ADDR_BITS'({1'b0, c[15:1]})
				                  : ADDR_BITS'({1'b0, d[15:1]});
			end
			wbc_pkg::OPC_JFWD: begin
				ex_out = out_q;
				ex_npc = pc_q + ADDR_BITS'(2) + ADDR_BITS'({1'b0, a[15:1]});
			end
			wbc_pkg::OPC_JBACK: begin
				ex_out = out_q;
				ex_npc = pc_q + ADDR_BITS'(2) - ADDR_BITS'({1'b0, a[15:1]});
			end
			wbc_pkg::OPC_BNE, wbc_pkg::OPC_BGT, wbc_pkg::OPC_BLT,
			wbc_pkg::OPC_BLE, wbc_pkg::OPC_BGE: begin
				ex_out = out_q;
				if (opc == wbc_pkg::OPC_BNE) begin
					taken = (x != y);
				end else if (opc == wbc_pkg::OPC_BGT) begin
					taken = (x > y);
				end else if (opc == wbc_pkg::OPC_BLT) begin
					taken = (x < y);
				end else if (opc == wbc_pkg::OPC_BLE) begin
					taken = (x <= y);
				end else begin
					taken = (x >= y);
				end
				ex_npc = taken ? br_taken : pc_q + ADDR_BITS'(4);
			end
			wbc_pkg::OPC_MUL: begin
				ex_wr1 = '{en: 1'b1, addr: wbc_pkg::ADR_PROD, data: prod[15:0]};
				ex_npc = pc_q + ADDR_BITS'(3);
			end
			wbc_pkg::OPC_DIV: begin
				// Write data is filled in when the divider finishes.
				ex_div = 1'b1;
				ex_npc = pc_q + ADDR_BITS'(3);
			end
			wbc_pkg::OPC_HALT: begin
				ex_out  = out_q;
				ex_halt = 1'b1;
				ex_npc  = pc_q;
			end
			default: begin
				ex_npc = pc_q + ADDR_BITS'(1);
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			pc_q       <= '0;
			out_q      <= '0;
			halt_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// In the done state the output valid is handled by that state alone.
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_op == wbc_pkg::ITEM_READ) begin
							state_q <= ST_RDATA;
						end else if (in_op == wbc_pkg::ITEM_EXEC && !halt_q) begin
							state_q <= ST_FETCH;
							step_q  <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RDATA: begin
					state_q <= ST_DONE;
				end
				ST_FETCH: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd7) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					pc_q   <= ex_npc;
					out_q  <= ex_out;
					halt_q <= ex_halt;
					state_q <= ex_div ? ST_DIV : ST_WR1;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_WR1;
					end
				end
				ST_WR1: begin
					state_q <= ST_WR2;
				end
				ST_WR2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= '0;
		end
		if (state_q == ST_RDATA) begin
			rdata_q <= rd_data;
		end
		if (state_q == ST_FETCH && step_q != 3'd0) begin
			words_q[step_q - 3'd1] <= rd_data;
		end
		if (state_q == ST_EXEC) begin
			wr1_q <= ex_wr1;
			wr2_q <= ex_wr2;
		end
		if (state_q == ST_DIV && div_done) begin
			wr1_q <= '{en: 1'b1, addr: wbc_pkg::ADR_QUOT, data: div_quot};
			wr2_q <= '{en: 1'b1, addr: wbc_pkg::ADR_REM, data: div_rem};
		end
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {7'd0, halt_q, 16'(pc_q), rdata_q, out_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	// No item is taken while the store is still being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("input accepted during store clearing");

	// Once halted, the processor stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag dropped");

	// The divider runs only while the sequencer waits for it.
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide state");

	// No store write while instruction words are being fetched or executed.
	a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_EXEC) |-> !wr_req.en)
		else $error("store write during fetch or execute");
`endif

endmodule
